// File: design/bilinear_image_scaler_defines.svh
// assertion macros shared by the scaler rtl
`ifndef BILINEAR_IMAGE_SCALER_DEFINES_SVH
`define BILINEAR_IMAGE_SCALER_DEFINES_SVH

// same-cycle implication, checked outside reset
`define BIS_ASSERT_SAME(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// next-cycle implication, checked outside reset
`define BIS_ASSERT_NEXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

// File: design/bis_pkg.sv
// shared types and constants of the bilinear scaler
package bis_pkg;

  localparam int COORD_W    = 12;
  localparam int CH_W       = 8;
  localparam int NUM_CH     = 3;
  localparam int PIX_W      = NUM_CH * CH_W;
  localparam int DIM_W      = 9;
  localparam int SCALE_W    = 24;
  localparam int CFG_DATA_W = 24;
  localparam int CFG_IDX_W  = 3;
  localparam int SIZE_W     = 13;
  localparam int FRAC_W     = 16;
  localparam int WGT1_W     = FRAC_W + 1;
  localparam int WGT_W      = 2 * FRAC_W + 1;
  localparam int P17_W      = COORD_W + 1 + SCALE_W;
  localparam int PROD_W     = WGT_W + CH_W;
  localparam int SUM_W      = PROD_W + 2;

  localparam int DEF_MAX_SOURCE_WIDTH  = 256;
  localparam int DEF_MAX_SOURCE_HEIGHT = 256;

  typedef enum logic {
    OP_LOAD    = 1'b0,
    OP_REQUEST = 1'b1
  } op_t;

  typedef enum logic [CFG_IDX_W-1:0] {
    REG_SOURCE_WIDTH    = 3'd0,
    REG_SOURCE_HEIGHT   = 3'd1,
    REG_INVERSE_SCALE_X = 3'd2,
    REG_INVERSE_SCALE_Y = 3'd3,
    REG_GRAY_MODE       = 3'd4
  } cfg_reg_t;

endpackage

// File: design/bis_in_if.sv
// input stream channel of the scaler
interface bis_in_if;
  import bis_pkg::*;

  logic              valid;
  logic              ready;
  op_t               operation;
  logic [COORD_W-1:0] coord_x;
  logic [COORD_W-1:0] coord_y;
  logic [CH_W-1:0]   chan0_in;
  logic [CH_W-1:0]   chan1_in;
  logic [CH_W-1:0]   chan2_in;

  modport source (output valid, operation, coord_x, coord_y, chan0_in, chan1_in, chan2_in,
                  input ready);
  modport sink (input valid, operation, coord_x, coord_y, chan0_in, chan1_in, chan2_in,
                output ready);
endinterface

// File: design/bis_out_if.sv
// result stream channel of the scaler
interface bis_out_if;
  import bis_pkg::*;

  logic            valid;
  logic            ready;
  logic [CH_W-1:0] chan0_out;
  logic [CH_W-1:0] chan1_out;
  logic [CH_W-1:0] chan2_out;

  modport source (output valid, chan0_out, chan1_out, chan2_out, input ready);
  modport sink (input valid, chan0_out, chan1_out, chan2_out, output ready);
endinterface

// File: design/bis_store.sv
// four-bank source pixel store, banked by column and row parity
module bis_store #(
  parameter int AW = 14
) (
  input  logic                      clk,
  input  logic                      rd_en,
  input  logic [3:0]                wr_en,
  input  logic [AW-1:0]             wr_addr,
  input  logic [bis_pkg::PIX_W-1:0] wr_data,
  input  logic [3:0][AW-1:0]        rd_addr,
  output logic [3:0][bis_pkg::PIX_W-1:0] rd_data
);
  import bis_pkg::*;

  localparam int DEPTH = 1 << AW;

  for (genvar b = 0; b < 4; b++) begin : g_bank
    logic [PIX_W-1:0] mem [DEPTH];

    always_ff @(posedge clk) begin
      if (wr_en[b]) begin
        mem[wr_addr] <= wr_data;
      end
    end

    always_ff @(posedge clk) begin
      if (rd_en) begin
        rd_data[b] <= mem[rd_addr[b]];
      end
    end
  end

endmodule

// File: design/bilinear_image_scaler.sv
// bilinear image scaler: pipelined four-neighbour interpolation over a banked pixel store
//
// Load beats write one 24-bit source pixel; request beats return one blended pixel.
// The block takes one beat per clock while results are taken, under any mix of loads
// and requests; a request's result passes stage 1 scale multiply, stage 2 clamp,
// stage 3 store read, stage 4 weight multiply, stage 5 sum, then the output register.
// The store is split into four banks by column and row parity so the four neighbours
// come out in a single read; loads write in the same stage in which requests read, so
// every request sees exactly the loads that were accepted before it. The whole pipeline
// advances only while the output register is empty or being taken, so backpressure on
// the result side stalls the input side. The store has no reset and no clearing pass:
// reading a pixel never loaded gives whatever the memory holds. Configuration is sampled
// live and must only change while the pipeline is empty.
`include "bilinear_image_scaler_defines.svh"

module bilinear_image_scaler #(
  parameter int MAX_SOURCE_WIDTH  = bis_pkg::DEF_MAX_SOURCE_WIDTH,
  parameter int MAX_SOURCE_HEIGHT = bis_pkg::DEF_MAX_SOURCE_HEIGHT
) (
  input  logic                           clk,
  input  logic                           rst_n,
  bis_in_if.sink                         in_ch,
  bis_out_if.source                      out_ch,
  input  logic                           cfg_we,
  input  logic [bis_pkg::CFG_IDX_W-1:0]  cfg_index,
  input  logic [bis_pkg::CFG_DATA_W-1:0] cfg_data
);
  import bis_pkg::*;

  // index widths, at least two bits so that parity and bank row both exist
  localparam int XW = (MAX_SOURCE_WIDTH > 2) ? $clog2(MAX_SOURCE_WIDTH) : 2;
  localparam int YW = (MAX_SOURCE_HEIGHT > 2) ? $clog2(MAX_SOURCE_HEIGHT) : 2;
  localparam int AW = (XW - 1) + (YW - 1);
  localparam logic [P17_W-1:0] HALF_P17 = P17_W'(32'h10000);

  // configuration registers
  logic [DIM_W-1:0]   width_r, height_r;
  logic [SCALE_W-1:0] inv_x_r, inv_y_r;
  logic               gray_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      width_r  <= DIM_W'(256);
      height_r <= DIM_W'(256);
      inv_x_r  <= SCALE_W'(32'h10000);
      inv_y_r  <= SCALE_W'(32'h10000);
      gray_r   <= 1'b0;
    end else if (cfg_we) begin
      unique case (cfg_index)
        REG_SOURCE_WIDTH:    width_r  <= cfg_data[DIM_W-1:0];
        REG_SOURCE_HEIGHT:   height_r <= cfg_data[DIM_W-1:0];
        REG_INVERSE_SCALE_X: inv_x_r  <= cfg_data[SCALE_W-1:0];
        REG_INVERSE_SCALE_Y: inv_y_r  <= cfg_data[SCALE_W-1:0];
        REG_GRAY_MODE:       gray_r   <= cfg_data[0];
        default: ;
      endcase
    end
  end

  function automatic logic [SIZE_W-1:0] clamp_size(input logic [DIM_W-1:0] v,
                                                   input logic [SIZE_W-1:0] maxv);
    logic [SIZE_W-1:0] e;
    e = SIZE_W'(v);
    if (e == '0) return SIZE_W'(1);
    if (e > maxv) return maxv;
    return e;
  endfunction

  // q20.16 position, floored, clamped to the last sample
  function automatic logic [P17_W-2:0] axis_pos(input logic [P17_W-1:0] p17,
                                                input logic [SIZE_W-1:0] size);
    logic [P17_W-1:0] d;
    logic [P17_W-2:0] pos, lim;
    d   = p17 - HALF_P17;
    pos = (p17 <= HALF_P17) ? '0 : d[P17_W-1:1];
    lim = (P17_W-1)'(size - SIZE_W'(1)) << FRAC_W;
    return (pos >= lim) ? lim : pos;
  endfunction

  // pipeline advance: output register free or being drained
  logic out_valid_r;
  logic advance;
  assign advance     = !out_valid_r || out_ch.ready;
  assign in_ch.ready = advance;

  // stage 1: accepted beat
  logic               v1_r;
  op_t                op1_r;
  logic [COORD_W-1:0] cx1_r, cy1_r;
  logic [PIX_W-1:0]   pix1_r;

  // stage 2: scaled coordinates
  logic               v2_r;
  op_t                op2_r;
  logic               inr2_r;
  logic [XW-1:0]      lx2_r;
  logic [YW-1:0]      ly2_r;
  logic [PIX_W-1:0]   pix2_r;
  logic [P17_W-1:0]   p17x_r, p17y_r;
  logic [P17_W-1:0]   p17x_nxt, p17y_nxt;
  logic               inr_nxt;

  assign p17x_nxt = P17_W'({cx1_r, 1'b1}) * P17_W'(inv_x_r);
  assign p17y_nxt = P17_W'({cy1_r, 1'b1}) * P17_W'(inv_y_r);
  assign inr_nxt  = ({1'b0, cx1_r} < SIZE_W'(MAX_SOURCE_WIDTH))
                 && ({1'b0, cy1_r} < SIZE_W'(MAX_SOURCE_HEIGHT));

  // stage 3: neighbour indices and fractions, store access
  logic               v3_r;
  op_t                op3_r;
  logic               inr3_r;
  logic [XW-1:0]      lx3_r;
  logic [YW-1:0]      ly3_r;
  logic [PIX_W-1:0]   pix3_r;
  logic [XW-1:0]      x0_r;
  logic [YW-1:0]      y0_r;
  logic [FRAC_W-1:0]  fx_r, fy_r;
  logic               ex3_r, ey3_r;

  logic [SIZE_W-1:0]  w_sz, h_sz;
  logic [P17_W-2:0]   posx, posy;
  logic [XW-1:0]      x0_nxt;
  logic [YW-1:0]      y0_nxt;

  assign w_sz   = clamp_size(width_r, SIZE_W'(MAX_SOURCE_WIDTH));
  assign h_sz   = clamp_size(height_r, SIZE_W'(MAX_SOURCE_HEIGHT));
  assign posx   = axis_pos(p17x_r, w_sz);
  assign posy   = axis_pos(p17y_r, h_sz);
  assign x0_nxt = posx[FRAC_W +: XW];
  assign y0_nxt = posy[FRAC_W +: YW];

  // bank addressing: each parity bank gets whichever of near/far has that parity
  logic [XW-1:0]            x1, col0, col1;
  logic [YW-1:0]            y1, row0, row1;
  logic [3:0][AW-1:0]       rd_addr;
  logic [3:0]               wr_en;
  logic [AW-1:0]            wr_addr;
  logic [3:0][PIX_W-1:0]    rd_data;

  assign x1   = x0_r + XW'(1);
  assign y1   = y0_r + YW'(1);
  assign col0 = x0_r[0] ? x1 : x0_r;
  assign col1 = x0_r[0] ? x0_r : x1;
  assign row0 = y0_r[0] ? y1 : y0_r;
  assign row1 = y0_r[0] ? y0_r : y1;
  assign rd_addr[0] = {row0[YW-1:1], col0[XW-1:1]};
  assign rd_addr[1] = {row0[YW-1:1], col1[XW-1:1]};
  assign rd_addr[2] = {row1[YW-1:1], col0[XW-1:1]};
  assign rd_addr[3] = {row1[YW-1:1], col1[XW-1:1]};
  assign wr_addr    = {ly3_r[YW-1:1], lx3_r[XW-1:1]};

  always_comb begin
    wr_en = '0;
    if (advance && v3_r && op3_r == OP_LOAD && inr3_r) begin
      wr_en[{ly3_r[0], lx3_r[0]}] = 1'b1;
    end
  end

  bis_store #(.AW(AW)) u_store (
    .clk     (clk),
    .rd_en   (advance),
    .wr_en   (wr_en),
    .wr_addr (wr_addr),
    .wr_data (pix3_r),
    .rd_addr (rd_addr),
    .rd_data (rd_data)
  );

  // corner weights, order 00 10 01 11
  logic [WGT1_W-1:0]     wx0, wy0;
  logic [3:0][WGT_W-1:0] wgt_nxt;

  assign wx0 = WGT1_W'(32'h10000) - WGT1_W'(fx_r);
  assign wy0 = WGT1_W'(32'h10000) - WGT1_W'(fy_r);
  assign wgt_nxt[0] = WGT_W'(wx0) * WGT_W'(wy0);
  assign wgt_nxt[1] = WGT_W'(fx_r) * WGT_W'(wy0);
  assign wgt_nxt[2] = WGT_W'(wx0) * WGT_W'(fy_r);
  assign wgt_nxt[3] = WGT_W'(fx_r) * WGT_W'(fy_r);

  // stage 4: store data arrives, select corners, weight them
  logic                  v4_r;
  op_t                   op4_r;
  logic                  xp4_r, yp4_r, ex4_r, ey4_r;
  logic [3:0][WGT_W-1:0] wgt_r;

  logic [3:0][PIX_W-1:0] corner;
  always_comb begin
    corner[0] = rd_data[{yp4_r, xp4_r}];
    corner[1] = ex4_r ? corner[0] : rd_data[{yp4_r, ~xp4_r}];
    corner[2] = ey4_r ? corner[0] : rd_data[{~yp4_r, xp4_r}];
    corner[3] = ex4_r ? corner[2] : (ey4_r ? corner[1] : rd_data[{~yp4_r, ~xp4_r}]);
  end

  logic [NUM_CH-1:0][3:0][PROD_W-1:0] prod_nxt;
  always_comb begin
    for (int c = 0; c < NUM_CH; c++) begin
      for (int k = 0; k < 4; k++) begin
        prod_nxt[c][k] = PROD_W'(wgt_r[k]) * PROD_W'(corner[k][c*CH_W +: CH_W]);
      end
    end
  end

  // stage 5: products, summed and rounded into the output register
  logic                               v5_r;
  op_t                                op5_r;
  logic [NUM_CH-1:0][3:0][PROD_W-1:0] prod_r;

  logic [NUM_CH-1:0][CH_W-1:0] chan_nxt;
  always_comb begin
    logic [SUM_W-1:0] s;
    logic [SUM_W-33:0] q;
    for (int c = 0; c < NUM_CH; c++) begin
      s = SUM_W'(prod_r[c][0]) + SUM_W'(prod_r[c][1]) + SUM_W'(prod_r[c][2])
        + SUM_W'(prod_r[c][3]) + SUM_W'(33'h080000000);
      q = s[SUM_W-1:32];
      chan_nxt[c] = (q > (SUM_W-32)'(255)) ? CH_W'(255) : q[CH_W-1:0];
      // gray mode leaves only the first channel
      if (gray_r && c != 0) begin
        chan_nxt[c] = '0;
      end
    end
  end

  logic [NUM_CH-1:0][CH_W-1:0] chan_r;

  // valid bits of the pipeline
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v1_r        <= 1'b0;
      v2_r        <= 1'b0;
      v3_r        <= 1'b0;
      v4_r        <= 1'b0;
      v5_r        <= 1'b0;
      out_valid_r <= 1'b0;
    end else if (advance) begin
      v1_r        <= in_ch.valid;
      v2_r        <= v1_r;
      v3_r        <= v2_r;
      v4_r        <= v3_r;
      v5_r        <= v4_r;
      out_valid_r <= v5_r && op5_r == OP_REQUEST;
    end
  end

  // payload of the pipeline
  always_ff @(posedge clk) begin
    if (advance) begin
      op1_r  <= in_ch.operation;
      cx1_r  <= in_ch.coord_x;
      cy1_r  <= in_ch.coord_y;
      pix1_r <= {in_ch.chan2_in, in_ch.chan1_in, in_ch.chan0_in};

      op2_r  <= op1_r;
      inr2_r <= inr_nxt;
      lx2_r  <= cx1_r[XW-1:0];
      ly2_r  <= cy1_r[YW-1:0];
      pix2_r <= pix1_r;
      p17x_r <= p17x_nxt;
      p17y_r <= p17y_nxt;

      op3_r  <= op2_r;
      inr3_r <= inr2_r;
      lx3_r  <= lx2_r;
      ly3_r  <= ly2_r;
      pix3_r <= pix2_r;
      x0_r   <= x0_nxt;
      y0_r   <= y0_nxt;
      fx_r   <= posx[FRAC_W-1:0];
      fy_r   <= posy[FRAC_W-1:0];
      ex3_r  <= (SIZE_W'(x0_nxt) == w_sz - SIZE_W'(1));
      ey3_r  <= (SIZE_W'(y0_nxt) == h_sz - SIZE_W'(1));

      op4_r  <= op3_r;
      xp4_r  <= x0_r[0];
      yp4_r  <= y0_r[0];
      ex4_r  <= ex3_r;
      ey4_r  <= ey3_r;
      wgt_r  <= wgt_nxt;

      op5_r  <= op4_r;
      prod_r <= prod_nxt;

      chan_r <= chan_nxt;
    end
  end

  assign out_ch.valid     = out_valid_r;
  assign out_ch.chan0_out = chan_r[0];
  assign out_ch.chan1_out = chan_r[1];
  assign out_ch.chan2_out = chan_r[2];

  // a request leaving stage 5 must land in the output register
  `BIS_ASSERT_NEXT(a_req_reaches_out, advance && v5_r && op5_r == OP_REQUEST, out_valid_r, "request lost at output")
  // a stall freezes every stage
  `BIS_ASSERT_NEXT(a_stall_holds, !advance, $stable({v1_r, v2_r, v3_r, v4_r, v5_r}), "pipeline moved during stall")
  // gray results carry only the first channel
  `BIS_ASSERT_SAME(a_gray_zero, out_valid_r && gray_r, chan_r[1] == '0 && chan_r[2] == '0, "gray result has color")
  // the store is never written while a stage stalls
  `BIS_ASSERT_SAME(a_no_write_in_stall, !advance, wr_en == '0, "store written during stall")

endmodule

// File: tb/bilinear_image_scaler_test.sv
// self-checking testbench of the bilinear image scaler
module bilinear_image_scaler_test;
  import bis_pkg::*;

  localparam int STORE_COLS  = DEF_MAX_SOURCE_WIDTH;
  localparam int STORE_ROWS  = DEF_MAX_SOURCE_HEIGHT;
  localparam int ITEM_TARGET = 1150;
  localparam int CYCLE_LIMIT = 1000000;
  localparam int DRAIN_WAIT  = 20;

  typedef struct packed {
    logic [CH_W-1:0] c0;
    logic [CH_W-1:0] c1;
    logic [CH_W-1:0] c2;
  } pixel_t;

  // one row of the directed stimulus; typed_exp marks a hand-written result
  typedef struct {
    op_t                operation;
    logic [COORD_W-1:0] x;
    logic [COORD_W-1:0] y;
    pixel_t             pix;
    bit                 typed_exp;
    pixel_t             exp_pix;
  } directed_row_t;

  logic clk;
  logic rst_n;
  logic                  cfg_we;
  logic [CFG_IDX_W-1:0]  cfg_index;
  logic [CFG_DATA_W-1:0] cfg_data;

  bis_in_if  in_ch ();
  bis_out_if out_ch ();

  bilinear_image_scaler dut (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_ch    (in_ch),
    .out_ch   (out_ch),
    .cfg_we   (cfg_we),
    .cfg_index(cfg_index),
    .cfg_data (cfg_data)
  );

  // 10 unit clock
  always begin
    clk = 1'b0;
    #5;
    clk = 1'b1;
    #5;
  end

  // shadow of the block: pixel store, which entries were loaded, live settings
  logic [PIX_W-1:0] shadow_pixels [0:STORE_COLS*STORE_ROWS-1];
  bit               pixel_loaded  [0:STORE_COLS*STORE_ROWS-1];
  logic [DIM_W-1:0]   set_width;
  logic [DIM_W-1:0]   set_height;
  logic [SCALE_W-1:0] set_scale_x;
  logic [SCALE_W-1:0] set_scale_y;
  logic               set_gray;

  pixel_t pending_pixels [$];
  int     mismatches;
  int     items_sent;
  bit     quiet_phase;   // no idling on either side while set
  longint cycle_count;

  // sizes of 0 act as 1, anything past the store saturates
  function automatic int unsigned usable_size(input logic [DIM_W-1:0] v, input int unsigned maxv);
    if (v == 0) return 1;
    if (v > maxv) return maxv;
    return v;
  endfunction

  // near index, far index and 16-bit fraction along one axis
  function automatic void map_axis(input int unsigned coord, input int unsigned scale,
                                   input int unsigned size, output int unsigned near_i,
                                   output int unsigned far_i, output int unsigned frac);
    longint unsigned p17;
    longint unsigned pos;
    longint unsigned lim;
    p17 = (2 * longint'(coord) + 1) * longint'(scale);
    pos = (p17 <= 65536) ? 0 : ((p17 - 65536) >> 1);
    lim = longint'(size - 1) << 16;
    if (pos >= lim) pos = lim;
    near_i = int'(pos >> 16);
    frac   = int'(pos & 64'hFFFF);
    far_i  = (near_i < size - 1) ? near_i + 1 : near_i;
  endfunction

  function automatic pixel_t blend_pixel(input int unsigned cx, input int unsigned cy);
    int unsigned w, h, x0, x1, fx, y0, y1, fy, sh;
    longint unsigned w00, w10, w01, w11, s, v;
    logic [PIX_W-1:0] p00, p10, p01, p11;
    logic [CH_W-1:0] ch [3];
    w = usable_size(set_width, STORE_COLS);
    h = usable_size(set_height, STORE_ROWS);
    map_axis(cx, set_scale_x, w, x0, x1, fx);
    map_axis(cy, set_scale_y, h, y0, y1, fy);
    w00 = (65536 - longint'(fx)) * (65536 - longint'(fy));
    w10 = longint'(fx) * (65536 - longint'(fy));
    w01 = (65536 - longint'(fx)) * longint'(fy);
    w11 = longint'(fx) * longint'(fy);
    p00 = shadow_pixels[y0 * STORE_COLS + x0];
    p10 = shadow_pixels[y0 * STORE_COLS + x1];
    p01 = shadow_pixels[y1 * STORE_COLS + x0];
    p11 = shadow_pixels[y1 * STORE_COLS + x1];
    for (int c = 0; c < 3; c++) begin
      sh = 8 * c;
      if (c == 0 || !set_gray) begin
        s = w00 * ((p00 >> sh) & 8'hFF) + w10 * ((p10 >> sh) & 8'hFF)
          + w01 * ((p01 >> sh) & 8'hFF) + w11 * ((p11 >> sh) & 8'hFF);
        v = (s + 64'h8000_0000) >> 32;
        if (v > 255) v = 255;
        ch[c] = v[7:0];
      end else begin
        ch[c] = '0;
      end
    end
    return '{c0: ch[0], c1: ch[1], c2: ch[2]};
  endfunction

  // random gap length: mostly short, a few long
  function automatic int gap_length();
    int r;
    if (quiet_phase) return 0;
    r = $urandom_range(0, 99);
    if (r < 65) return 0;
    if (r < 95) return $urandom_range(1, 3);
    return $urandom_range(10, 60);
  endfunction

  // drive one beat and wait for it to be taken; shadow updated on acceptance
  task automatic send_beat(input op_t op, input int unsigned x, input int unsigned y,
                           input pixel_t pix, input bit typed_exp, input pixel_t exp_pix);
    int gap;
    gap = gap_length();
    if (gap > 0) begin
      in_ch.valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_ch.valid     <= 1'b1;
    in_ch.operation <= op;
    in_ch.coord_x   <= x[COORD_W-1:0];
    in_ch.coord_y   <= y[COORD_W-1:0];
    in_ch.chan0_in  <= pix.c0;
    in_ch.chan1_in  <= pix.c1;
    in_ch.chan2_in  <= pix.c2;
    do @(posedge clk); while (!in_ch.ready);
    items_sent++;
    if (op == OP_LOAD) begin
      if (x < STORE_COLS && y < STORE_ROWS) begin
        shadow_pixels[y * STORE_COLS + x] = {pix.c2, pix.c1, pix.c0};
        pixel_loaded[y * STORE_COLS + x]  = 1'b1;
      end
    end else begin
      pending_pixels.push_back(typed_exp ? exp_pix : blend_pixel(x, y));
    end
  endtask

  function automatic pixel_t random_pixel();
    return '{c0: CH_W'($urandom_range(0, 255)), c1: CH_W'($urandom_range(0, 255)),
             c2: CH_W'($urandom_range(0, 255))};
  endfunction

  // wait for the pipeline to empty, loads leave nothing in the queue to wait on
  task automatic wait_idle();
    in_ch.valid <= 1'b0;
    while (pending_pixels.size() > 0) @(posedge clk);
    repeat (DRAIN_WAIT) @(posedge clk);
  endtask

  task automatic write_settings(input int unsigned w, input int unsigned h,
                                input int unsigned sx, input int unsigned sy, input bit gray);
    logic [CFG_DATA_W-1:0] vals [5];
    cfg_reg_t regs [5];
    vals = '{w[CFG_DATA_W-1:0], h[CFG_DATA_W-1:0], sx[CFG_DATA_W-1:0],
             sy[CFG_DATA_W-1:0], CFG_DATA_W'(gray)};
    regs = '{REG_SOURCE_WIDTH, REG_SOURCE_HEIGHT, REG_INVERSE_SCALE_X,
             REG_INVERSE_SCALE_Y, REG_GRAY_MODE};
    for (int i = 0; i < 5; i++) begin
      cfg_we    <= 1'b1;
      cfg_index <= regs[i];
      cfg_data  <= vals[i];
      @(posedge clk);
    end
    cfg_we      <= 1'b0;
    set_width   = w[DIM_W-1:0];
    set_height  = h[DIM_W-1:0];
    set_scale_x = sx[SCALE_W-1:0];
    set_scale_y = sy[SCALE_W-1:0];
    set_gray    = gray;
    @(posedge clk);
  endtask

  function automatic int unsigned random_scale();
    int r;
    r = $urandom_range(0, 9);
    if (r == 0) return 0;
    if (r == 1) return 1;
    if (r == 2) return 24'hFFFFFF;
    if (r == 3) return $urandom_range(0, 24'hFFFFFF);
    return $urandom_range(16'h2000, 20'h40000);
  endfunction

  // one phase: new settings, fill the readable region, then mixed traffic
  task automatic run_phase(input int phase_no);
    int unsigned w, h, sx, sy, ew, eh, x, y, reqs;
    bit gray;
    int r;
    pixel_t none;
    none = '0;
    case (phase_no)
      0: begin w = 256; h = 1;   sx = 24'hFFFFFF; sy = 1;          gray = 0; end
      1: begin w = 1;   h = 256; sx = 0;          sy = 24'hFFFFFF; gray = 1; end
      2: begin w = 0;   h = 511; sx = 1;          sy = 0;          gray = 0; end
      3: begin w = 511; h = 0;   sx = 16'h8000;   sy = 20'h18000;  gray = 1; end
      default: begin
        w = $urandom_range(0, 14);
        h = $urandom_range(0, 14);
        sx = random_scale();
        sy = random_scale();
        gray = $urandom_range(0, 1);
      end
    endcase
    quiet_phase = ($urandom_range(0, 3) == 0);
    write_settings(w, h, sx, sy, gray);
    ew = usable_size(w, STORE_COLS);
    eh = usable_size(h, STORE_ROWS);
    // every pixel a request may touch must be loaded first
    for (int yy = 0; yy < eh; yy++)
      for (int xx = 0; xx < ew; xx++)
        if (!pixel_loaded[yy * STORE_COLS + xx])
          send_beat(OP_LOAD, xx, yy, random_pixel(), 1'b0, none);
    reqs = $urandom_range(50, 90);
    for (int i = 0; i < reqs; i++) begin
      r = $urandom_range(0, 99);
      if (r < 12) begin
        send_beat(OP_LOAD, $urandom_range(0, ew - 1), $urandom_range(0, eh - 1),
                  random_pixel(), 1'b0, none);
      end else if (r < 20) begin
        // outside the store, must be dropped
        x = $urandom_range(0, 4095);
        y = (x < STORE_COLS) ? $urandom_range(STORE_ROWS, 4095) : $urandom_range(0, 4095);
        send_beat(OP_LOAD, x, y, random_pixel(), 1'b0, none);
      end else begin
        if ($urandom_range(0, 1)) begin
          x = $urandom_range(0, 4095);
          y = $urandom_range(0, 4095);
        end else begin
          x = $urandom_range(0, 2 * ew + 2);
          y = $urandom_range(0, 2 * eh + 2);
        end
        send_beat(OP_REQUEST, x, y, '0, 1'b0, none);
      end
    end
    wait_idle();
  endtask

  directed_row_t directed_rows [] = '{
    // corners of the full store at reset settings, extreme channel values
    '{OP_LOAD,    12'd0,    12'd0,    '{8'h00, 8'hFF, 8'h80}, 1'b0, '0},
    '{OP_LOAD,    12'd255,  12'd255,  '{8'hFF, 8'h00, 8'h01}, 1'b0, '0},
    '{OP_LOAD,    12'd0,    12'd255,  '{8'h12, 8'h34, 8'h56}, 1'b0, '0},
    '{OP_LOAD,    12'd255,  12'd0,    '{8'hAB, 8'hCD, 8'hEF}, 1'b0, '0},
    // zero-weight far neighbours of the requests below
    '{OP_LOAD,    12'd1,    12'd0,    '{8'h21, 8'h43, 8'h65}, 1'b0, '0},
    '{OP_LOAD,    12'd0,    12'd1,    '{8'h87, 8'hA9, 8'hCB}, 1'b0, '0},
    '{OP_LOAD,    12'd1,    12'd1,    '{8'hED, 8'h0F, 8'h31}, 1'b0, '0},
    '{OP_LOAD,    12'd255,  12'd1,    '{8'h53, 8'h75, 8'h97}, 1'b0, '0},
    '{OP_LOAD,    12'd1,    12'd255,  '{8'hB9, 8'hDB, 8'hFD}, 1'b0, '0},
    // outside the store: dropped, must not disturb the corners
    '{OP_LOAD,    12'd4095, 12'd4095, '{8'h55, 8'h55, 8'h55}, 1'b0, '0},
    '{OP_LOAD,    12'd256,  12'd0,    '{8'h77, 8'h77, 8'h77}, 1'b0, '0},
    '{OP_LOAD,    12'd0,    12'd256,  '{8'h66, 8'h66, 8'h66}, 1'b0, '0},
    // unit scale lands exactly on source pixels, far coords clamp to the edge
    '{OP_REQUEST, 12'd0,    12'd0,    '0, 1'b1, '{8'h00, 8'hFF, 8'h80}},
    '{OP_REQUEST, 12'd4095, 12'd4095, '0, 1'b1, '{8'hFF, 8'h00, 8'h01}},
    '{OP_REQUEST, 12'd255,  12'd0,    '0, 1'b1, '{8'hAB, 8'hCD, 8'hEF}},
    '{OP_REQUEST, 12'd0,    12'd4095, '0, 1'b1, '{8'h12, 8'h34, 8'h56}},
    '{OP_REQUEST, 12'd300,  12'd0,    '0, 1'b1, '{8'hAB, 8'hCD, 8'hEF}},
    '{OP_REQUEST, 12'd255,  12'd255,  '0, 1'b1, '{8'hFF, 8'h00, 8'h01}}
  };

  // stimulus
  initial begin
    int phase_no;
    rst_n           <= 1'b0;
    cfg_we          <= 1'b0;
    cfg_index       <= REG_SOURCE_WIDTH;
    cfg_data        <= '0;
    in_ch.valid     <= 1'b0;
    in_ch.operation <= OP_LOAD;
    in_ch.coord_x   <= '0;
    in_ch.coord_y   <= '0;
    in_ch.chan0_in  <= '0;
    in_ch.chan1_in  <= '0;
    in_ch.chan2_in  <= '0;
    items_sent  = 0;
    quiet_phase = 1'b0;
    set_width   = 9'd256;
    set_height  = 9'd256;
    set_scale_x = 24'd65536;
    set_scale_y = 24'd65536;
    set_gray    = 1'b0;
    for (int i = 0; i < STORE_COLS * STORE_ROWS; i++) begin
      shadow_pixels[i] = '0;
      pixel_loaded[i]  = 1'b0;
    end
    repeat (7) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);
    foreach (directed_rows[i])
      send_beat(directed_rows[i].operation, directed_rows[i].x, directed_rows[i].y,
                directed_rows[i].pix, directed_rows[i].typed_exp, directed_rows[i].exp_pix);
    // sender holds off until every result is back
    wait_idle();
    phase_no = 0;
    while (items_sent < ITEM_TARGET) begin
      run_phase(phase_no);
      phase_no++;
    end
    wait_idle();
    if (mismatches == 0) begin
      $display("== PASS ==");
    end else begin
      $display("== FAIL ==");
    end
    $finish;
  end

  // result side: check each beat, then pick next ready with random stalls
  int stall_left;

  always @(posedge clk) begin
    pixel_t got;
    pixel_t want;
    if (rst_n && out_ch.valid && out_ch.ready) begin
      got = '{c0: out_ch.chan0_out, c1: out_ch.chan1_out, c2: out_ch.chan2_out};
      if (pending_pixels.size() == 0) begin
        mismatches++;
        if (mismatches <= 10)
          $display("unexpected result beat %h %h %h", got.c0, got.c1, got.c2);
      end else begin
        want = pending_pixels.pop_front();
        if (got !== want) begin
          mismatches++;
          if (mismatches <= 10)
            $display("result mismatch: expected %h %h %h, got %h %h %h",
                     want.c0, want.c1, want.c2, got.c0, got.c1, got.c2);
        end
      end
    end
    if (!rst_n) begin
      stall_left    <= 0;
      out_ch.ready  <= 1'b0;
    end else if (stall_left > 0) begin
      stall_left    <= stall_left - 1;
      out_ch.ready  <= 1'b0;
    end else if (!quiet_phase && $urandom_range(0, 99) < 30) begin
      stall_left    <= ($urandom_range(0, 19) == 0) ? $urandom_range(10, 60)
                                                    : $urandom_range(0, 2);
      out_ch.ready  <= 1'b0;
    end else begin
      out_ch.ready  <= 1'b1;
    end
  end

  // watchdog
  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count > CYCLE_LIMIT) begin
      $display("== FAIL ==");
      $finish;
    end
  end

endmodule
